// ===== src/mgd_pkg.sv =====
package mgd_pkg;

    localparam int MAX_ITEMS  = 1024;
    localparam int VALUE_BITS = 30;
    localparam int ADDR_BITS  = $clog2(MAX_ITEMS);
    localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
    localparam int SHIFT_BITS = $clog2(VALUE_BITS);

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [ADDR_BITS-1:0]  t_addr;
    typedef logic [CNT_BITS-1:0]   t_count;
    typedef logic [SHIFT_BITS-1:0] t_shift;

    localparam t_count COUNT_FULL = CNT_BITS'(MAX_ITEMS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_READ,
        ST_CAND_GO,
        ST_CAND_WAIT,
        ST_SUF_GO,
        ST_SUF_WAIT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic   start;
        t_value a;
        t_value b;
    } t_gcd_req;

    typedef struct packed {
        logic   done;
        t_value result;
    } t_gcd_rsp;

endpackage

// ===== src/mgd_ram.sv =====
module mgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/mgd_gcd.sv =====
module mgd_gcd (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mgd_pkg::t_gcd_req  i_req,
    output mgd_pkg::t_gcd_rsp  o_rsp
);

    // Binary GCD: one shift or one subtract per cycle, common factors of two
    // are counted in r_k and restored when one operand reaches zero.
    mgd_pkg::t_value r_a, n_a;
    mgd_pkg::t_value r_b, n_b;
    mgd_pkg::t_shift r_k, n_k;
    mgd_pkg::t_value r_res, n_res;
    logic            r_busy, n_busy;
    logic            r_done, n_done;

    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_k    = r_k;
        n_res  = r_res;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_k    = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            priority if (r_a == '0) begin
                n_res  = r_b << r_k;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (r_b == '0) begin
                n_res  = r_a << r_k;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (!r_a[0] && !r_b[0]) begin
                n_a = r_a >> 1;
                n_b = r_b >> 1;
                n_k = r_k + 1'b1;
            end else if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (r_a >= r_b) begin
                n_a = r_a - r_b;
            end else begin
                n_b = r_b - r_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_k   <= n_k;
        r_res <= n_res;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

// ===== src/max_gcd_delete_one.sv =====
// Takes a list of values, one per transfer, the final one marked by i_last, and
// returns one result per list: the largest GCD left after deleting any single
// element. All GCDs run on one binary GCD unit (a shift or subtract per
// cycle), so each element costs one GCD run while o_ready is held low.
// After the final element of a list of two or more, the block walks its
// two 1024-entry stores backward, spending two GCD runs per stored element.
// A list of more than MAX_ITEMS elements gives a result with o_overflow set
// and a zero GCD. The result sits in an output register, so loading of the
// next list may begin while it waits to be taken.
module max_gcd_delete_one (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [mgd_pkg::VALUE_BITS-1:0]     i_value,
    input  logic                               i_last,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [mgd_pkg::VALUE_BITS-1:0]     o_max_gcd,
    output logic                               o_overflow
);

    mgd_pkg::t_state r_state, n_state;
    mgd_pkg::t_count r_count, n_count;
    mgd_pkg::t_value r_prefix, n_prefix;
    mgd_pkg::t_value r_suffix, n_suffix;
    mgd_pkg::t_value r_best, n_best;
    logic            r_ovf, n_ovf;
    mgd_pkg::t_addr  r_idx, n_idx;
    mgd_pkg::t_value r_val, n_val;
    logic            r_last, n_last;
    mgd_pkg::t_value r_res, n_res;
    logic            r_o_valid, n_o_valid;
    mgd_pkg::t_value r_o_max, n_o_max;
    logic            r_o_ovf, n_o_ovf;

    mgd_pkg::t_gcd_req s_req;
    mgd_pkg::t_gcd_rsp s_rsp;
    mgd_pkg::t_value   s_val_rd;
    mgd_pkg::t_value   s_pre_rd;
    logic              s_ram_we;
    logic              s_ram_re;
    logic              s_in_xfer;
    logic              s_full;

    assign s_in_xfer = i_valid && o_ready;
    assign s_full    = (r_count == mgd_pkg::COUNT_FULL);

    mgd_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_req),
        .o_rsp   (s_rsp)
    );

    mgd_ram #(
        .WIDTH (mgd_pkg::VALUE_BITS),
        .DEPTH (mgd_pkg::MAX_ITEMS)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (s_ram_we),
        .i_waddr (r_count[mgd_pkg::ADDR_BITS-1:0]),
        .i_wdata (r_val),
        .i_re    (s_ram_re),
        .i_raddr (r_idx),
        .o_rdata (s_val_rd)
    );

    mgd_ram #(
        .WIDTH (mgd_pkg::VALUE_BITS),
        .DEPTH (mgd_pkg::MAX_ITEMS)
    ) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (s_ram_we),
        .i_waddr (r_count[mgd_pkg::ADDR_BITS-1:0]),
        .i_wdata (s_rsp.result),
        .i_re    (s_ram_re),
        .i_raddr (r_idx - 1'b1),
        .o_rdata (s_pre_rd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mgd_pkg::ST_IDLE: begin
                if (s_in_xfer) begin
                    if (!s_full) begin
                        n_state = mgd_pkg::ST_LOAD;
                    end else if (i_last) begin
                        n_state = mgd_pkg::ST_FINISH;
                    end
                end
            end
            mgd_pkg::ST_LOAD: begin
                if (s_rsp.done) begin
                    if (!r_last) begin
                        n_state = mgd_pkg::ST_IDLE;
                    end else if (r_count == '0) begin
                        n_state = mgd_pkg::ST_FINISH;
                    end else begin
                        n_state = mgd_pkg::ST_READ;
                    end
                end
            end
            mgd_pkg::ST_READ:     n_state = mgd_pkg::ST_CAND_GO;
            mgd_pkg::ST_CAND_GO:  n_state = mgd_pkg::ST_CAND_WAIT;
            mgd_pkg::ST_CAND_WAIT: begin
                if (s_rsp.done) begin
                    n_state = mgd_pkg::ST_SUF_GO;
                end
            end
            mgd_pkg::ST_SUF_GO:   n_state = mgd_pkg::ST_SUF_WAIT;
            mgd_pkg::ST_SUF_WAIT: begin
                if (s_rsp.done) begin
                    n_state = (r_idx == '0) ? mgd_pkg::ST_FINISH : mgd_pkg::ST_READ;
                end
            end
            mgd_pkg::ST_FINISH: begin
                if (!r_o_valid) begin
                    n_state = mgd_pkg::ST_IDLE;
                end
            end
            default: n_state = mgd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = 1'b0;
        s_req.start = 1'b0;
        s_req.a     = r_suffix;
        s_req.b     = s_val_rd;
        s_ram_we    = 1'b0;
        s_ram_re    = 1'b0;
        unique case (r_state)
            mgd_pkg::ST_IDLE: begin
                o_ready     = 1'b1;
                s_req.start = s_in_xfer && !s_full;
                s_req.a     = r_prefix;
                s_req.b     = i_value;
            end
            mgd_pkg::ST_LOAD: begin
                s_ram_we = s_rsp.done;
            end
            mgd_pkg::ST_READ: begin
                s_ram_re = 1'b1;
            end
            mgd_pkg::ST_CAND_GO: begin
                s_req.start = 1'b1;
                s_req.a     = (r_idx == '0) ? '0 : s_pre_rd;
                s_req.b     = r_suffix;
            end
            mgd_pkg::ST_SUF_GO: begin
                s_req.start = 1'b1;
            end
            mgd_pkg::ST_CAND_WAIT,
            mgd_pkg::ST_SUF_WAIT,
            mgd_pkg::ST_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_prefix  = r_prefix;
        n_suffix  = r_suffix;
        n_best    = r_best;
        n_ovf     = r_ovf;
        n_idx     = r_idx;
        n_val     = r_val;
        n_last    = r_last;
        n_res     = r_res;
        n_o_valid = r_o_valid;
        n_o_max   = r_o_max;
        n_o_ovf   = r_o_ovf;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            mgd_pkg::ST_IDLE: begin
                if (s_in_xfer) begin
                    n_val  = i_value;
                    n_last = i_last;
                    if (s_full) begin
                        n_ovf = 1'b1;
                        n_res = '0;
                    end
                end
            end
            mgd_pkg::ST_LOAD: begin
                if (s_rsp.done) begin
                    n_prefix = s_rsp.result;
                    n_count  = r_count + 1'b1;
                    n_res    = r_val;
                    n_idx    = r_count[mgd_pkg::ADDR_BITS-1:0];
                    n_suffix = '0;
                    n_best   = '0;
                end
            end
            mgd_pkg::ST_CAND_WAIT: begin
                if (s_rsp.done && (s_rsp.result > r_best)) begin
                    n_best = s_rsp.result;
                end
            end
            mgd_pkg::ST_SUF_WAIT: begin
                if (s_rsp.done) begin
                    n_suffix = s_rsp.result;
                    n_res    = r_best;
                    n_idx    = r_idx - 1'b1;
                end
            end
            mgd_pkg::ST_FINISH: begin
                if (!r_o_valid) begin
                    n_o_valid = 1'b1;
                    n_o_max   = r_ovf ? '0 : r_res;
                    n_o_ovf   = r_ovf;
                    n_count   = '0;
                    n_prefix  = '0;
                    n_suffix  = '0;
                    n_best    = '0;
                    n_ovf     = 1'b0;
                end
            end
            mgd_pkg::ST_READ,
            mgd_pkg::ST_CAND_GO,
            mgd_pkg::ST_SUF_GO: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mgd_pkg::ST_IDLE;
            r_count   <= '0;
            r_prefix  <= '0;
            r_suffix  <= '0;
            r_best    <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_prefix  <= n_prefix;
            r_suffix  <= n_suffix;
            r_best    <= n_best;
            r_ovf     <= n_ovf;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_val   <= n_val;
        r_last  <= n_last;
        r_res   <= n_res;
        r_o_max <= n_o_max;
        r_o_ovf <= n_o_ovf;
    end

    assign o_valid    = r_o_valid;
    assign o_max_gcd  = r_o_max;
    assign o_overflow = r_o_ovf;

endmodule

// ===== src/mgd_chk.sv =====
module mgd_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic [mgd_pkg::VALUE_BITS-1:0] i_value,
    input logic                           i_last,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [mgd_pkg::VALUE_BITS-1:0] o_max_gcd,
    input logic                           o_overflow
);

    // Lists whose final element has been taken but whose result is not yet out.
    logic [2:0] r_pend;
    logic [2:0] n_pend;
    logic       s_in_end;
    logic       s_out_xfer;

    assign s_in_end   = i_valid && o_ready && i_last;
    assign s_out_xfer = o_valid && i_ready;

    always_comb begin
        n_pend = r_pend;
        if (s_in_end && !s_out_xfer) begin
            n_pend = r_pend + 1'b1;
        end else if (!s_in_end && s_out_xfer) begin
            n_pend = r_pend - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_max_gcd) && $stable(o_overflow))
        else $error("result changed or dropped before its transfer");

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_max_gcd == '0)
        else $error("overflowed list returned a non-zero GCD");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pend != '0)
        else $error("result offered with no finished list outstanding");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 3'd2)
        else $error("more than two lists outstanding");

endmodule

bind max_gcd_delete_one mgd_chk u_mgd_chk (.*);

// ===== test/tb_max_gcd_delete_one.sv =====
module tb_max_gcd_delete_one;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              WATCHDOG_LIMIT = 600000;
    localparam int              RANDOM_ITEMS   = 1400;
    localparam int              HOLD_CYCLES    = 3000;
    localparam mgd_pkg::t_value MAX_VAL        = '1;

    typedef enum int {
        LIST_RANDOM,
        LIST_COMMON,
        LIST_SAME,
        LIST_POW2
    } t_list_kind;

    typedef struct packed {
        mgd_pkg::t_value value;
        logic            last;
    } t_list_item;

    typedef struct packed {
        mgd_pkg::t_value max_gcd;
        logic            overflow;
    } t_gcd_result;

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            o_ready;
    mgd_pkg::t_value i_value = '0;
    logic            i_last  = 1'b0;
    logic            o_valid;
    logic            i_ready = 1'b0;
    mgd_pkg::t_value o_max_gcd;
    logic            o_overflow;

    max_gcd_delete_one DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_value    (i_value),
        .i_last     (i_last),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_max_gcd  (o_max_gcd),
        .o_overflow (o_overflow)
    );

    always #4 i_clk = ~i_clk;

    t_list_item      pending_items[$];
    t_gcd_result     expected_results[$];
    mgd_pkg::t_value list_buf[$];

    mgd_pkg::t_value value_mem[mgd_pkg::MAX_ITEMS];
    mgd_pkg::t_value prefix_mem[mgd_pkg::MAX_ITEMS];
    int              list_len      = 0;
    mgd_pkg::t_value prefix_gcd    = '0;
    logic            list_overflow = 1'b0;

    int          error_count  = 0;
    int          idle_cycles  = 0;
    int          results_seen = 0;
    logic        in_transfer  = 1'b0;

    int          burst_left = 1;
    int          gap_left   = 0;

    int          hold_left     = 0;
    int          holds_done    = 0;
    int          next_hold_at  = 8;
    int          pattern_age   = 0;
    logic [15:0] stall_pattern = '1;

    function automatic mgd_pkg::t_value gcd_of(input mgd_pkg::t_value a,
                                               input mgd_pkg::t_value b);
        int unsigned x;
        int unsigned y;
        int unsigned r;
        x = a;
        y = b;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return mgd_pkg::t_value'(x);
    endfunction

    task automatic absorb_value(input mgd_pkg::t_value v, input logic fin);
        mgd_pkg::t_value suffix;
        mgd_pkg::t_value before_gcd;
        mgd_pkg::t_value cand;
        mgd_pkg::t_value best;
        t_gcd_result     res;
        best = '0;
        if (list_len >= mgd_pkg::MAX_ITEMS) begin
            list_overflow = 1'b1;
        end else begin
            prefix_gcd           = gcd_of(prefix_gcd, v);
            value_mem[list_len]  = v;
            prefix_mem[list_len] = prefix_gcd;
            list_len++;
        end
        if (fin) begin
            if (!list_overflow) begin
                if (list_len == 1) begin
                    best = value_mem[0];
                end else begin
                    suffix = '0;
                    for (int idx = list_len - 1; idx >= 0; idx--) begin
                        before_gcd = (idx == 0) ? mgd_pkg::t_value'(0) : prefix_mem[idx-1];
                        cand       = gcd_of(before_gcd, suffix);
                        if (cand > best) begin
                            best = cand;
                        end
                        suffix = gcd_of(suffix, value_mem[idx]);
                    end
                end
            end
            res.max_gcd  = best;
            res.overflow = list_overflow;
            expected_results.push_back(res);
            list_len      = 0;
            prefix_gcd    = '0;
            list_overflow = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic mgd_pkg::t_value rand_value();
        mgd_pkg::t_value v;
        v = mgd_pkg::t_value'($urandom);
        if (v == 0) begin
            v = 1;
        end
        return v;
    endfunction

    task automatic flush_list();
        t_list_item it;
        foreach (list_buf[k]) begin
            it.value = list_buf[k];
            it.last  = (k == list_buf.size() - 1);
            pending_items.push_back(it);
        end
        list_buf.delete();
    endtask

    task automatic build_list(input int n, input t_list_kind kind);
        int unsigned     g;
        int unsigned     m;
        int unsigned     sh;
        int              odd_pos;
        mgd_pkg::t_value base;
        mgd_pkg::t_value v;
        sh      = $urandom_range(0, 29);
        g       = 1 + ($urandom & ((32'd1 << sh) - 1));
        base    = rand_value();
        odd_pos = ($urandom_range(0, 1) == 0) ? $urandom_range(0, n - 1) : -1;
        for (int k = 0; k < n; k++) begin
            case (kind)
                LIST_COMMON: begin
                    m = $urandom_range(1, MAX_VAL / g);
                    v = mgd_pkg::t_value'(g * m);
                end
                LIST_SAME: begin
                    v = base;
                end
                LIST_POW2: begin
                    sh = $urandom_range(0, 29);
                    v  = mgd_pkg::t_value'(32'd1 << sh);
                    if (sh < 28 && $urandom_range(0, 1) == 1) begin
                        v = mgd_pkg::t_value'(v * 3);
                    end
                end
                default: begin
                    v = rand_value();
                end
            endcase
            if (k == odd_pos && kind != LIST_RANDOM) begin
                v = rand_value();
            end
            list_buf.push_back(v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_transfer = i_valid && o_ready;
            if (in_transfer) begin
                absorb_value(i_value, i_last);
            end
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result gcd=%0d overflow=%0b",
                                              o_max_gcd, o_overflow));
                end else begin
                    if (o_max_gcd !== expected_results[0].max_gcd) begin
                        report_mismatch($sformatf("max_gcd got %0d, expected %0d",
                                                  o_max_gcd, expected_results[0].max_gcd));
                    end
                    if (o_overflow !== expected_results[0].overflow) begin
                        report_mismatch($sformatf("overflow got %0b, expected %0b",
                                                  o_overflow, expected_results[0].overflow));
                    end
                    void'(expected_results.pop_front());
                end
            end
            if (in_transfer || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    always @(negedge i_clk) begin
        t_list_item it;
        if (i_rst_n && (!i_valid || in_transfer)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                i_value <= it.value;
                i_last  <= it.last;
                i_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 3) == 0) begin
                        gap_left = 0;
                    end else if ($urandom_range(0, 9) == 0) begin
                        gap_left = $urandom_range(1, 40);
                    end else begin
                        gap_left = $urandom_range(1, 5);
                    end
                end else begin
                    burst_left--;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // The receiver holds off for long stretches a few times, so that the result
    // register fills and the input side is stalled.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (holds_done < 3 && results_seen >= next_hold_at) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
            next_hold_at += 30;
            i_ready <= 1'b0;
        end else begin
            if (pattern_age == 0) begin
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
                pattern_age   = 64;
            end
            pattern_age--;
            i_ready <= stall_pattern[pattern_age % 16];
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int random_items;
        int n;
        logic long_done;
        random_items = 0;
        long_done    = 1'b0;

        list_buf = '{MAX_VAL};
        flush_list();
        list_buf = '{mgd_pkg::t_value'(1)};
        flush_list();
        list_buf = '{mgd_pkg::t_value'(1), MAX_VAL};
        flush_list();
        list_buf = '{MAX_VAL, MAX_VAL, MAX_VAL};
        flush_list();
        list_buf = '{mgd_pkg::t_value'(12), mgd_pkg::t_value'(18),
                     mgd_pkg::t_value'(7), mgd_pkg::t_value'(24)};
        flush_list();
        list_buf = '{mgd_pkg::t_value'(7), mgd_pkg::t_value'(12),
                     mgd_pkg::t_value'(18), mgd_pkg::t_value'(24)};
        flush_list();
        list_buf = '{mgd_pkg::t_value'(12), mgd_pkg::t_value'(18),
                     mgd_pkg::t_value'(24), mgd_pkg::t_value'(7)};
        flush_list();
        list_buf = '{mgd_pkg::t_value'(1 << 29), mgd_pkg::t_value'(1 << 28),
                     mgd_pkg::t_value'(1 << 27)};
        flush_list();
        list_buf = '{mgd_pkg::t_value'(30'h2AAAAAAA), mgd_pkg::t_value'(30'h15555555)};
        flush_list();

        while (random_items < RANDOM_ITEMS) begin
            if (!long_done && random_items >= (RANDOM_ITEMS - mgd_pkg::MAX_ITEMS) / 2) begin
                // A list that fills the store and then overruns it by two elements.
                build_list(mgd_pkg::MAX_ITEMS + 2, LIST_RANDOM);
                flush_list();
                random_items += mgd_pkg::MAX_ITEMS + 2;
                long_done = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: n = $urandom_range(1, 4);
                5, 6, 7, 8:    n = $urandom_range(5, 16);
                default:       n = $urandom_range(17, 48);
            endcase
            build_list(n, t_list_kind'($urandom_range(0, 3)));
            flush_list();
            random_items += n;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (400) @(posedge i_clk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
